/* sv/mbrc_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the Modbus response checker.
`default_nettype none

package mbrc_pkg;

  // Channel widths.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CountW   = 9;
  localparam int unsigned MTdataW  = 40;  // 16 + 3 + 16 bits, padded to whole bytes

  // Frame constants.
  localparam logic [WordW-1:0]  CrcPoly      = 16'hA001;
  localparam logic [WordW-1:0]  CrcInit      = 16'hFFFF;
  localparam logic [ByteW-1:0]  ExcMask      = 8'h80;
  localparam logic [ByteW-1:0]  FuncReadHold = 8'h03;
  localparam logic [ByteW-1:0]  AddrReset    = 8'h01;
  localparam logic [CountW-1:0] CountMax     = 9'd511;
  localparam logic [CountW:0]   MinFrameLen  = 10'd5;
  localparam logic [CountW:0]   HeaderLen    = 10'd3;

  // Result kinds.
  localparam logic KindWord   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Frame status codes.
  localparam logic [StatusW-1:0] StOk        = 3'd0;
  localparam logic [StatusW-1:0] StShort     = 3'd1;
  localparam logic [StatusW-1:0] StAddress   = 3'd2;
  localparam logic [StatusW-1:0] StException = 3'd3;
  localparam logic [StatusW-1:0] StFunction  = 3'd4;
  localparam logic [StatusW-1:0] StTruncated = 3'd5;
  localparam logic [StatusW-1:0] StCrc       = 3'd6;
  localparam logic [StatusW-1:0] StOddCount  = 3'd7;

  // One result beat as held in the output queue.
  typedef struct packed {
    logic               kind;
    logic [WordW-1:0]   word;
    logic [StatusW-1:0] status;
    logic [WordW-1:0]   detail;
    logic               last;
  } result_t;

  // Reflected CRC-16 update over one byte, eight shift steps unrolled.
  function automatic logic [WordW-1:0] crc_byte(input logic [WordW-1:0] crc_in,
                                                input logic [ByteW-1:0] data);
    logic [WordW-1:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < ByteW; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/modbus_register_response_checker_core.sv */
// Modbus RTU read-holding-registers response checker: byte stream in, words and status out.
`default_nettype none

// Channel   | Direction | Beat contents
// ----------+-----------+--------------------------------------------------------------
// s_axis    | in        | tdata: received frame byte; tlast: final byte of the frame
// m_axis    | out       | tdata: register word, frame status, status detail;
//           |           | tuser: kind (0 word, 1 status); tlast: last result of a byte
// cfg       | in        | data: expected device address (reset value 1)
//
// A byte beat is taken into an input register and processed from there by one pass of logic
// (CRC byte update and the frame checks), which pushes up to two results into a four-entry
// output queue. One byte is accepted per cycle while the queue has room for two results; a
// byte that yields a word and a status pushes both, and m_axis drains them one by one.
// Reset clears the frame state, the input register and the queue; no clearing pass follows.
// A stall on m_axis fills the queue and then holds s_axis_tready low.

module modbus_register_response_checker_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Received byte stream.
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [mbrc_pkg::ByteW-1:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic                         s_axis_tlast,   // end_of_frame
  // Result stream.
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [mbrc_pkg::MTdataW-1:0]      m_axis_tdata,   // [15:0] register_word,
                                                            // [18:16] frame_status,
                                                            // [34:19] status_detail,
                                                            // [39:35] zero
  output logic                              m_axis_tuser,   // [0] item_kind
  output logic                              m_axis_tlast,   // last_result
  // Configuration write channel.
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [mbrc_pkg::ByteW-1:0]   cfg_data_i      // expected_address
);
  import mbrc_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  // Input register.
  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              in_eof_q;

  // Configuration.
  logic [ByteW-1:0]  exp_addr_q;

  // Frame state.
  logic [CountW-1:0] seen_q, seen_d;
  logic [WordW-1:0]  run_crc_q, run_crc_d;
  logic [WordW-1:0]  pay_crc_q, pay_crc_d;
  logic [WordW-1:0]  trl_crc_q, trl_crc_d;
  logic [ByteW-1:0]  addr_q, addr_d;
  logic [ByteW-1:0]  func_q, func_d;
  logic [ByteW-1:0]  dlen_q, dlen_d;
  logic [ByteW-1:0]  hold_q, hold_d;

  // Output queue.
  result_t           queue_q [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]  cnt_q;

  logic              proc;
  logic              pop;
  logic              push_word;
  logic              push_stat;
  logic [1:0]        n_push;
  result_t           word_res;
  result_t           stat_res;
  result_t           first_res;
  result_t           head;

  // Per-byte working values.
  logic [CountW-1:0] p;
  logic [CountW:0]   pay_end;
  logic [CountW:0]   len_w;
  logic [CountW-1:0] len;
  logic              in_payload;
  logic [WordW-1:0]  crc_new;
  logic [StatusW-1:0] st;
  logic [WordW-1:0]  det;

  // The byte waits in the input register until the queue can take both possible results.
  assign proc          = in_valid_q && (cnt_q <= QCntW'(QDepth - 2));
  assign s_axis_tready = !in_valid_q || proc;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    seen_d    = seen_q;
    run_crc_d = run_crc_q;
    pay_crc_d = pay_crc_q;
    trl_crc_d = trl_crc_q;
    addr_d    = addr_q;
    func_d    = func_q;
    dlen_d    = dlen_q;
    hold_d    = hold_q;
    push_word = 1'b0;
    push_stat = 1'b0;
    st        = StOk;
    det       = '0;

    p = seen_q;

    // The third byte carries the data length and already sets where the payload ends.
    if (p == CountW'(2)) begin
      pay_end = HeaderLen + {2'b00, in_byte_q};
    end else begin
      pay_end = HeaderLen + {2'b00, dlen_q};
    end
    in_payload = {1'b0, p} < pay_end;
    crc_new    = crc_byte(run_crc_q, in_byte_q);

    if (p < CountMax) begin
      len = p + CountW'(1);
    end else begin
      len = CountMax;
    end
    len_w = {1'b0, len};

    if (proc) begin
      unique case (p)
        CountW'(0): addr_d = in_byte_q;
        CountW'(1): func_d = in_byte_q;
        CountW'(2): dlen_d = in_byte_q;
        default: ;
      endcase

      if (in_payload) begin
        run_crc_d = crc_new;
        pay_crc_d = crc_new;
        if (p >= CountW'(3)) begin
          // Data bytes at odd positions open a pair; even positions close it.
          if (p[0]) begin
            hold_d = in_byte_q;
          end else begin
            push_word = 1'b1;
          end
        end
      end else if ({1'b0, p} == pay_end) begin
        trl_crc_d = {trl_crc_q[WordW-1:ByteW], in_byte_q};
      end else if ({1'b0, p} == pay_end + (CountW+1)'(1)) begin
        trl_crc_d = {in_byte_q, trl_crc_q[ByteW-1:0]};
      end

      seen_d = len;

      if (in_eof_q) begin
        push_stat = 1'b1;
        // Checks run on the state as it stands after this byte, in fixed priority.
        priority if (len_w < MinFrameLen) begin
          st = StShort;
        end else if (addr_d != exp_addr_q) begin
          st  = StAddress;
          det = {8'h00, addr_d};
        end else if ((func_d & ExcMask) != '0) begin
          st  = StException;
          det = {8'h00, dlen_d};
        end else if (func_d != FuncReadHold) begin
          st  = StFunction;
          det = {8'h00, func_d};
        end else if (len_w < {2'b00, dlen_d} + MinFrameLen) begin
          st = StTruncated;
        end else if (pay_crc_d != trl_crc_d) begin
          st  = StCrc;
          det = pay_crc_d;
        end else if (dlen_d[0]) begin
          st = StOddCount;
        end else begin
          st = StOk;
        end

        // The frame is over: back to the reset state for the next one.
        seen_d    = '0;
        run_crc_d = CrcInit;
        pay_crc_d = '0;
        trl_crc_d = '0;
        addr_d    = '0;
        func_d    = '0;
        dlen_d    = '0;
        hold_d    = '0;
      end
    end
  end

  always_comb begin
    word_res.kind   = KindWord;
    word_res.word   = {hold_q, in_byte_q};
    word_res.status = StOk;
    word_res.detail = '0;
    word_res.last   = !push_stat;

    stat_res.kind   = KindStatus;
    stat_res.word   = '0;
    stat_res.status = st;
    stat_res.detail = det;
    stat_res.last   = 1'b1;

    first_res = push_word ? word_res : stat_res;
    n_push    = {1'b0, push_word} + {1'b0, push_stat};
  end

  assign head          = queue_q[rd_q];
  assign m_axis_tvalid = cnt_q != '0;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {5'b00000, head.detail, head.status, head.word};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      exp_addr_q <= AddrReset;
      seen_q     <= '0;
      run_crc_q  <= CrcInit;
      pay_crc_q  <= '0;
      trl_crc_q  <= '0;
      addr_q     <= '0;
      func_q     <= '0;
      dlen_q     <= '0;
      hold_q     <= '0;
      wr_q       <= '0;
      rd_q       <= '0;
      cnt_q      <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (cfg_valid_i) begin
        exp_addr_q <= cfg_data_i;
      end
      seen_q    <= seen_d;
      run_crc_q <= run_crc_d;
      pay_crc_q <= pay_crc_d;
      trl_crc_q <= trl_crc_d;
      addr_q    <= addr_d;
      func_q    <= func_d;
      dlen_q    <= dlen_d;
      hold_q    <= hold_d;
      wr_q      <= wr_q + QPtrW'(n_push);
      if (pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(n_push) - QCntW'(pop);
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eof_q  <= s_axis_tlast;
    end
    if (n_push != 2'd0) begin
      queue_q[wr_q] <= first_res;
    end
    if (n_push == 2'd2) begin
      queue_q[wr_q + QPtrW'(1)] <= stat_res;
    end
  end

  // The queue never holds more results than it has entries.
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("output queue overflow");

  // A byte held back by a queue without room for two results is still there in the next cycle.
  a_byte_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc) |=> in_valid_q)
    else $error("held byte lost");

  // Processing the final byte of a frame restarts the byte count and the CRC.
  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_eof_q) |=> (seen_q == '0 && run_crc_q == CrcInit))
    else $error("frame state not cleared after final byte");

  // A status result always closes the results of its byte.
  a_status_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("status result not marked last");

endmodule

`default_nettype wire
